@@ design/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned PadStart   = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  // control from the top level to the compression core
  typedef struct packed {
    logic       start;
    logic       init_chain;
  } core_ctrl_t;

  typedef struct packed {
    logic       busy;
    logic       done;
  } core_stat_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic word_t sig0(input word_t v);
    return ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t sig1(input word_t v);
    return ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
  endfunction

endpackage

@@ design/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256 of a byte message with padding and digest readout.
// ----------------------------------------------------------------------------
// Byte beats are packed into the block memory while ready is high; every 64th
// byte starts a compression that holds off input until it is done (a start,
// 16 word loads from the memory, 64 rounds on the single round unit, a chain
// add and a done pulse). An end beat pads the block word by word, runs one or
// two compressions, then delivers eight digest beats, one per cycle when the
// sink is ready.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        message_end,
  input  logic        valid,
  output logic        ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        out_valid,
  input  logic        out_ready
);

  typedef enum logic [2:0] {
    S_IN, S_COMP, S_PAD, S_COMP1, S_LEN, S_COMP2, S_OUT
  } state_t;

  state_t               state;
  sha_pkg::word_t       mem [16];
  sha_pkg::word_t       rdata;
  logic [3:0]           raddr;
  sha_pkg::word_t       cur;        // word being filled
  logic [5:0]           fill;
  logic [60:0]          byte_count;
  logic [3:0]           pidx;
  logic                 end_pend;
  sha_pkg::core_ctrl_t  ctrl;
  sha_pkg::core_ctrl_t  ctrl_next;
  sha_pkg::core_stat_t  stat;
  sha_pkg::word_t       chain [8];
  sha_pkg::word_t       cur_next;
  logic [63:0]          bits;
  logic                 accept;

  assign accept = valid && ready;
  assign ready  = (state == S_IN);
  assign bits   = {byte_count, 3'b000};

  always_comb begin
    unique case (fill[1:0])
      2'd0: cur_next = {data_byte, 24'd0};
      2'd1: cur_next = {cur[31:24], data_byte, 16'd0};
      2'd2: cur_next = {cur[31:16], data_byte, 8'd0};
      default: cur_next = {cur[31:8], data_byte};
    endcase
  end

  // one-cycle pulses to the core
  always_comb begin
    ctrl_next.start = ((state == S_IN) && accept && byte_valid && (fill == 6'd63))
                   || ((state == S_PAD) && (pidx == 4'd15)
                       && (fill >= 6'(sha_pkg::PadStart)))
                   || (state == S_LEN);
    ctrl_next.init_chain = (state == S_OUT) && out_ready && (word_index == 3'd7);
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  sha_core u_core (
    .clk(clk), .rst(rst), .ctrl(ctrl), .blk_rdata(rdata),
    .blk_raddr(raddr), .stat(stat), .chain(chain)
  );

  assign digest_word = chain[word_index];
  assign last_word   = (word_index == 3'd7);
  assign out_valid   = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
      fill <= '0;
      byte_count <= '0;
      cur <= '0;
      end_pend <= 1'b0;
      pidx <= '0;
      word_index <= '0;
      ctrl <= '0;
    end else begin
      ctrl <= ctrl_next;
      unique case (state)
        S_IN: begin
          if (accept) begin
            if (byte_valid) begin
              if (fill[1:0] == 2'd3) mem[fill[5:2]] <= cur_next;
              fill <= fill + 6'd1;
              byte_count <= byte_count + 61'd1;
            end
            end_pend <= message_end;
            if (byte_valid && fill == 6'd63) begin
              state <= S_COMP;
              cur <= '0;
            end else begin
              if (byte_valid) begin
                cur <= cur_next;
              end
              if (message_end) begin
                state <= S_PAD;
                pidx <= '0;
              end
            end
          end
        end
        S_COMP: begin
          if (stat.done) begin
            if (end_pend) begin
              state <= S_PAD;
              pidx <= '0;
            end else begin
              state <= S_IN;
            end
          end
        end
        S_PAD: begin
          // write pad word and zero the rest; length goes in later
          if (pidx < fill[5:2]) begin
            pidx <= pidx + 4'd1;
          end else begin
            if (pidx == fill[5:2]) begin
              unique case (fill[1:0])
                2'd0: mem[pidx] <= {sha_pkg::PadByte, 24'd0};
                2'd1: mem[pidx] <= {cur[31:24], sha_pkg::PadByte, 16'd0};
                2'd2: mem[pidx] <= {cur[31:16], sha_pkg::PadByte, 8'd0};
                default: mem[pidx] <= {cur[31:8], sha_pkg::PadByte};
              endcase
            end else begin
              mem[pidx] <= '0;
            end
            pidx <= pidx + 4'd1;
            if (pidx == 4'd15) begin
              if (fill >= 6'(sha_pkg::PadStart)) begin
                state <= S_COMP1;
              end else begin
                state <= S_LEN;
              end
            end
          end
        end
        S_COMP1: begin
          if (stat.done) begin
            state <= S_LEN;
            for (int i = 0; i < 14; i++) mem[i] <= '0;
          end
        end
        S_LEN: begin
          mem[14] <= bits[63:32];
          mem[15] <= bits[31:0];
          state <= S_COMP2;
        end
        S_COMP2: begin
          if (stat.done) begin
            state <= S_OUT;
            word_index <= '0;
          end
        end
        default: begin
          if (out_ready) begin
            word_index <= word_index + 3'd1;
            if (word_index == 3'd7) begin
              state <= S_IN;
              fill <= '0;
              byte_count <= '0;
              cur <= '0;
              end_pend <= 1'b0;
            end
          end
        end
      endcase
    end
  end

endmodule

@@ design/sha_core.sv @@
// ----------------------------------------------------------------------------
// sha_core
// Compression engine: one round per cycle, schedule kept in a 16-entry ring.
// The message words come from the block memory of the top level.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::core_ctrl_t ctrl,
  input  sha_pkg::word_t      blk_rdata,
  output logic [3:0]          blk_raddr,
  output sha_pkg::core_stat_t stat,
  output sha_pkg::word_t      chain [8]
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ROUND, S_ADD} state_t;

  state_t           state;
  logic [5:0]       cnt;
  logic             done;
  sha_pkg::word_t   w [16];
  sha_pkg::word_t   a, b, c, d, e, f, g, h;
  sha_pkg::word_t   wt, t1, t2;
  logic [5:0]       rnd;

  // memory read address runs one ahead of the load counter
  assign blk_raddr = (state == S_IDLE) ? 4'd0 : cnt[3:0] + 4'd1;
  assign rnd = cnt;

  always_comb begin
    if (rnd < 6'd16) begin
      wt = w[rnd[3:0]];
    end else begin
      wt = w[rnd[3:0]] + sha_pkg::sig0(w[rnd[3:0] + 4'd1])
         + w[rnd[3:0] + 4'd9] + sha_pkg::sig1(w[rnd[3:0] + 4'd14]);
    end
    t1 = h + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
       + ((e & f) ^ (~e & g)) + sha_pkg::round_k(rnd) + wt;
    t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
       + ((a & b) ^ (a & c) ^ (b & c));
  end

  assign stat = {(state != S_IDLE), done};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      done <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::init_h(3'(i));
    end else begin
      done <= (state == S_ADD);
      unique case (state)
        S_IDLE: begin
          if (ctrl.init_chain) begin
            for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::init_h(3'(i));
          end
          if (ctrl.start) begin
            state <= S_LOAD;
            cnt <= '0;
          end
        end
        S_LOAD: begin
          w[cnt[3:0]] <= blk_rdata;
          if (cnt == 6'd15) begin
            state <= S_ROUND;
            cnt <= '0;
            a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3];
            e <= chain[4]; f <= chain[5]; g <= chain[6]; h <= chain[7];
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_ROUND: begin
          w[rnd[3:0]] <= wt;
          h <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(sha_pkg::Rounds - 1)) state <= S_ADD;
        end
        default: begin
          chain[0] <= chain[0] + a; chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c; chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e; chain[5] <= chain[5] + f;
          chain[6] <= chain[6] + g; chain[7] <= chain[7] + h;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
